@@ rtl/assert_macros.svh @@
// Assertion macros shared by the sort batcher modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ rtl/slsb_pkg.sv @@
// ----------------------------------------------------------------------------
// slsb_pkg
// Shared types, constants and helpers of the sprite layer sort batcher.
// ----------------------------------------------------------------------------
package slsb_pkg;

	localparam int MAX_QUADS_DEF = 64;
	localparam int KEY_W = 32;
	localparam int PAIR_W = 32;
	localparam int SLOT_W = 6;
	localparam int HANDLE_W = 16;
	localparam int LIMIT_W = 7;
	localparam int VBASE_W = 8;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int OP_W = 2;

	localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
	localparam logic [OP_W-1:0] OP_SUBMIT = 2'd1;
	localparam logic [OP_W-1:0] OP_END = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_DEF_TEX = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEF_NRM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BATCH_LIMIT = 2'd2;

	localparam logic [HANDLE_W-1:0] DEF_TEX_RST = 16'd1;
	localparam logic [HANDLE_W-1:0] DEF_NRM_RST = 16'd2;
	localparam logic [LIMIT_W-1:0] BATCH_LIMIT_RST = 7'd64;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAIR_W-1:0] pair;
		logic [SLOT_W-1:0] slot;
	} quad_t;

	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctl_t;

	// Flipping the sign bits makes an unsigned compare order by signed layer, then z.
	function automatic logic [KEY_W-1:0] make_key(input logic [15:0] layer_bits,
		input logic [15:0] z_bits);
		return {~layer_bits[15], layer_bits[14:0], ~z_bits[15], z_bits[14:0]};
	endfunction

	function automatic logic [HANDLE_W-1:0] resolve(input logic [HANDLE_W-1:0] handle,
		input logic [HANDLE_W-1:0] fallback);
		return (handle != '0) ? handle : fallback;
	endfunction

endpackage

@@ rtl/slsb_cell.sv @@
// ----------------------------------------------------------------------------
// slsb_cell
// One slot of the insertion sort chain: keeps one quad, shifts right on insert
// when its key is greater, and shifts left while the list is drained.
// ----------------------------------------------------------------------------
module slsb_cell #(
	parameter int MAX_QUADS = slsb_pkg::MAX_QUADS_DEF,
	parameter int IDX = 0,
	localparam int CNT_W = $clog2(MAX_QUADS + 1)
) (
	input  logic clk,
	input  slsb_pkg::cell_ctl_t ctl,
	input  logic [CNT_W-1:0] count,
	input  slsb_pkg::quad_t new_item,
	input  slsb_pkg::quad_t left_item,
	input  logic left_take,
	input  slsb_pkg::quad_t right_item,
	output slsb_pkg::quad_t item,
	output logic take
);
	import slsb_pkg::*;

	quad_t item_q;

	assign take = (count <= CNT_W'(IDX)) || (item_q.key > new_item.key);
	assign item = item_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			item_q <= right_item;
		end else if (ctl.insert && take) begin
			item_q <= left_take ? left_item : new_item;
		end
	end

endmodule

@@ rtl/slsb_batch.sv @@
// ----------------------------------------------------------------------------
// slsb_batch
// Batch marking and result register: opens a batch at the first result, on a handle
// change or at the size limit, counts vertex bases and registers each result beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slsb_batch (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  logic fire,
	input  slsb_pkg::quad_t head,
	input  logic [slsb_pkg::LIMIT_W-1:0] limit,
	input  logic ovf,
	input  logic is_last,
	output logic strobe,
	output logic [slsb_pkg::SLOT_W-1:0] arrival_slot,
	output logic [slsb_pkg::HANDLE_W-1:0] out_texture,
	output logic [slsb_pkg::HANDLE_W-1:0] out_normal,
	output logic batch_start,
	output logic [slsb_pkg::VBASE_W-1:0] vertex_base,
	output logic overflow,
	output logic last
);
	import slsb_pkg::*;

	logic first_q;
	logic [PAIR_W-1:0] cur_pair_q;
	logic [LIMIT_W-1:0] in_batch_q;
	logic [LIMIT_W-1:0] limit_eff;
	logic [LIMIT_W-1:0] base_idx;
	logic brk;

	assign limit_eff = (limit == '0) ? LIMIT_W'(1) : limit;
	assign brk = first_q || (head.pair != cur_pair_q) || (in_batch_q >= limit_eff);
	assign base_idx = brk ? '0 : in_batch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b0;
			strobe <= 1'b0;
		end else begin
			strobe <= fire;
			if (load) begin
				first_q <= 1'b1;
			end else if (fire) begin
				first_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			cur_pair_q <= head.pair;
			in_batch_q <= base_idx + LIMIT_W'(1);
			arrival_slot <= head.slot;
			out_texture <= head.pair[PAIR_W-1:HANDLE_W];
			out_normal <= head.pair[HANDLE_W-1:0];
			batch_start <= brk;
			vertex_base <= {base_idx[VBASE_W-3:0], 2'b00};
			overflow <= ovf;
			last <= is_last;
		end
	end

	`ASSERT_NEXT(a_first_opens_batch, clk, arst_n, fire && first_q, strobe && batch_start)
	`ASSERT_SAME(a_inner_base_nonzero, clk, arst_n, strobe && !batch_start, vertex_base != '0)

endmodule

@@ rtl/sprite_layer_sort_batcher.sv @@
// ----------------------------------------------------------------------------
// sprite_layer_sort_batcher
// Draw-list sorter and batcher built on a chain of insertion cells.
// ----------------------------------------------------------------------------
// Begin and submit beats may arrive in every cycle while busy is low.
// A submit is sorted into the cell chain on entry; the compare in each cell picks its place.
// An end beat with stored quads keeps busy high until every quad is sent; emitting_q is set
// on acceptance, each result strobe is registered from it and one result follows every cycle.
// Reset clears the quad count, overflow flag and emission state and sets the registers
// to 1, 2 and 64; stored quads are undefined. Results cannot be stalled by the receiver.
`include "assert_macros.svh"

module sprite_layer_sort_batcher #(
	parameter int MAX_QUADS = slsb_pkg::MAX_QUADS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [slsb_pkg::OP_W-1:0] operation,
	input  logic signed [15:0] layer,
	input  logic signed [15:0] z_order,
	input  logic [slsb_pkg::HANDLE_W-1:0] texture_id,
	input  logic [slsb_pkg::HANDLE_W-1:0] normal_id,
	input  logic wr_en,
	input  logic [slsb_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [slsb_pkg::CFG_DATA_W-1:0] wr_data,
	output logic strobe,
	output logic [slsb_pkg::SLOT_W-1:0] arrival_slot,
	output logic [slsb_pkg::HANDLE_W-1:0] out_texture,
	output logic [slsb_pkg::HANDLE_W-1:0] out_normal,
	output logic batch_start,
	output logic [slsb_pkg::VBASE_W-1:0] vertex_base,
	output logic overflow,
	output logic last
);
	import slsb_pkg::*;

	localparam int CNT_W = $clog2(MAX_QUADS + 1);

	logic [HANDLE_W-1:0] def_tex_q;
	logic [HANDLE_W-1:0] def_nrm_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [CNT_W-1:0] count_q;
	logic ovf_q;
	logic emitting_q;

	logic accept;
	logic full;
	logic load;
	cell_ctl_t ctl;
	quad_t new_item;
	quad_t cell_item [MAX_QUADS];
	logic cell_take [MAX_QUADS];

	assign busy = emitting_q;
	assign accept = start && !emitting_q;
	assign full = (count_q >= CNT_W'(MAX_QUADS));
	assign ctl.insert = accept && (operation == OP_SUBMIT) && !full;
	assign ctl.shift = emitting_q;
	assign load = accept && (operation == OP_END) && (count_q != '0);

	assign new_item.key = make_key(layer, z_order);
	assign new_item.pair = {resolve(texture_id, def_tex_q), resolve(normal_id, def_nrm_q)};
	assign new_item.slot = SLOT_W'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_tex_q <= DEF_TEX_RST;
			def_nrm_q <= DEF_NRM_RST;
			limit_q <= BATCH_LIMIT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DEF_TEX: begin
					def_tex_q <= wr_data;
				end
				REG_DEF_NRM: begin
					def_nrm_q <= wr_data;
				end
				REG_BATCH_LIMIT: begin
					limit_q <= wr_data[LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q <= 1'b0;
			emitting_q <= 1'b0;
		end else if (emitting_q) begin
			count_q <= count_q - CNT_W'(1);
			if (count_q == CNT_W'(1)) begin
				emitting_q <= 1'b0;
				ovf_q <= 1'b0;
			end
		end else if (accept) begin
			unique case (operation)
				OP_BEGIN: begin
					count_q <= '0;
					ovf_q <= 1'b0;
				end
				OP_SUBMIT: begin
					if (full) begin
						ovf_q <= 1'b1;
					end else begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				OP_END: begin
					if (count_q == '0) begin
						ovf_q <= 1'b0;
					end else begin
						emitting_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	for (genvar i = 0; i < MAX_QUADS; i++) begin : g_cell
		quad_t left_item;
		logic left_take;
		quad_t right_item;

		if (i == 0) begin : g_head
			assign left_item = new_item;
			assign left_take = 1'b0;
		end else begin : g_body
			assign left_item = cell_item[i-1];
			assign left_take = cell_take[i-1];
		end

		if (i == MAX_QUADS - 1) begin : g_tail
			assign right_item = cell_item[i];
		end else begin : g_inner
			assign right_item = cell_item[i+1];
		end

		slsb_cell #(
			.MAX_QUADS(MAX_QUADS),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.ctl(ctl),
			.count(count_q),
			.new_item(new_item),
			.left_item(left_item),
			.left_take(left_take),
			.right_item(right_item),
			.item(cell_item[i]),
			.take(cell_take[i])
		);
	end

	slsb_batch u_batch (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.fire(emitting_q),
		.head(cell_item[0]),
		.limit(limit_q),
		.ovf(ovf_q),
		.is_last(count_q == CNT_W'(1)),
		.strobe(strobe),
		.arrival_slot(arrival_slot),
		.out_texture(out_texture),
		.out_normal(out_normal),
		.batch_start(batch_start),
		.vertex_base(vertex_base),
		.overflow(overflow),
		.last(last)
	);

	`ASSERT_SAME(a_busy_nonempty, clk, arst_n, emitting_q, count_q != '0)
	`ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_QUADS))
	`ASSERT_SAME(a_last_drained, clk, arst_n, strobe && last, count_q == '0 && !emitting_q)
	`ASSERT_NEXT(a_full_sets_ovf, clk, arst_n, accept && operation == OP_SUBMIT && full, ovf_q)

endmodule
